### rtl/osst_pkg.sv
// Package with the shared constants, types and helpers of the ordered set store.
`timescale 1ns / 1ps

package osst_pkg;

  // Number of cells, and so the most entries the store holds.
  localparam int unsigned CAPACITY = 16;
  // Bits of a stored element.
  localparam int unsigned VALUE_WIDTH = 32;
  // Bits of the entry counter, wide enough to hold CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Width of the value field and of the entry count field on the ports.
  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned OUT_COUNT_W = 5;

  // Operation codes; the unused code behaves as a query.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef logic [VALUE_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0] count_t;

  // Command broadcast from the control logic to every cell.
  typedef struct packed {
    logic ins_en;  // write the key into the cell at the fill position
    logic del_en;  // cells at and past the match take their right neighbor
  } osst_cmd_t;

  // The element is sign-extended from the port and kept in its low bits.
  function automatic key_t to_key(input logic signed [IN_VALUE_W-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[VALUE_WIDTH-1:0];
  endfunction

endpackage

### rtl/osst_cell.sv
// One storage cell of the ordered set store: an entry, its comparator and shift mux.
`timescale 1ns / 1ps

module osst_cell (
  input  logic               clk_i,
  input  osst_pkg::osst_cmd_t cmd_i,
  input  logic               occupied_i,
  input  logic               load_slot_i,
  input  osst_pkg::key_t     key_i,
  input  logic               hit_i,
  input  osst_pkg::key_t     shift_data_i,
  output logic               hit_o,
  output osst_pkg::key_t     entry_o
);
  import osst_pkg::*;

  key_t entry_q, entry_d;
  logic match;

  // Only a held entry can match; the hit flag runs along the row to the right.
  assign match   = occupied_i && (entry_q == key_i);
  assign hit_o   = hit_i || match;
  assign entry_o = entry_q;

  // A delete closes the gap: this cell and every later one take the right neighbor.
  always_comb begin
    entry_d = entry_q;
    priority if (cmd_i.del_en && hit_o) begin
      entry_d = shift_data_i;
    end else if (cmd_i.ins_en && load_slot_i) begin
      entry_d = key_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### rtl/ordered_set_store.sv
// Top level of the ordered set store: a row of cells, the entry counter and the result register.
// Usage:
//   The input channel carries an operation (insert, delete or membership query)
//   and a 32-bit signed value. The output channel returns one result per item:
//   whether the value was held beforehand, the entry count after the operation,
//   the full and empty flags, and a flag for an insert dropped on a full store.
//   Both channels use valid and stall; a transfer happens on a rising edge with
//   valid high and stall low.
//   Throughput is one item per cycle when not stalled. Every cell compares
//   its entry with the value in the cycle of the transfer and the row shifts
//   at the same edge, so the next item sees the updated contents at once.
//   The result is registered at the edge that takes the item and is shown
//   from the next cycle on.
//   When the receiver stalls, the result holds in the output register and the
//   input stalls as well until that result leaves; a new item is taken in the
//   same cycle as the waiting result goes out.
//   Reset empties the store (count zero) and clears the output valid. The cell
//   contents are not cleared; only entries below the count are ever compared.
`timescale 1ns / 1ps

module ordered_set_store (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic signed [osst_pkg::IN_VALUE_W-1:0] value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 was_member_o,
  output logic [osst_pkg::OUT_COUNT_W-1:0]     entry_count_o,
  output logic                                 is_full_o,
  output logic                                 is_empty_o,
  output logic                                 rejected_o
);
  import osst_pkg::*;

  localparam count_t CAP_CNT = count_t'(CAPACITY);

  key_t      key;
  key_t      entry [CAPACITY];
  logic      hit [CAPACITY+1];
  logic      member;
  logic      full_now;
  logic      in_fire;
  logic      reject;
  osst_cmd_t cmd;

  count_t count_q, count_d;
  logic   out_valid_q, out_valid_d;
  logic   was_member_q;
  logic [OUT_COUNT_W-1:0] entry_count_q;
  logic   is_full_q, is_empty_q, rejected_q;

  // A new item is taken unless a finished result is stuck at the output.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign key        = to_key(value_i);

  // Row of cells; the hit flag enters at the left end.
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t shift_data;
    if (i == CAPACITY - 1) begin : g_last
      assign shift_data = key;
    end else begin : g_mid
      assign shift_data = entry[i+1];
    end
    osst_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occupied_i   (count_t'(i) < count_q),
      .load_slot_i  (count_t'(i) == count_q),
      .key_i        (key),
      .hit_i        (hit[i]),
      .shift_data_i (shift_data),
      .hit_o        (hit[i+1]),
      .entry_o      (entry[i])
    );
  end

  assign member   = hit[CAPACITY];
  assign full_now = (count_q >= CAP_CNT);

  // Decode the operation into the cell command and the new count.
  always_comb begin
    cmd     = '0;
    reject  = 1'b0;
    count_d = count_q;
    priority if (op_i == OP_INSERT) begin
      if (!member) begin
        if (full_now) begin
          reject = 1'b1;
        end else begin
          cmd.ins_en = in_fire;
          count_d    = count_q + count_t'(1);
        end
      end
    end else if (op_i == OP_DELETE) begin
      if (member) begin
        cmd.del_en = in_fire;
        count_d    = count_q - count_t'(1);
      end
    end else begin
      count_d = count_q;
    end
  end

  // Output register is loaded on a transfer and cleared when its result leaves.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      was_member_q  <= member;
      entry_count_q <= OUT_COUNT_W'(count_d);
      is_full_q     <= (count_d == CAP_CNT);
      is_empty_q    <= (count_d == '0);
      rejected_q    <= reject;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign was_member_o  = was_member_q;
  assign entry_count_o = entry_count_q;
  assign is_full_o     = is_full_q;
  assign is_empty_o    = is_empty_q;
  assign rejected_o    = rejected_q;

  // The count never grows past the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count exceeds capacity");

  // A dropped insert only happens on a full store and for a value not held.
  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (is_full_o && !was_member_o))
    else $error("rejected result without a full store");

  // An accepted insert of a new value adds exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd.ins_en) |=> (count_q == count_t'($past(count_q) + count_t'(1))))
    else $error("insert did not add one entry");

  // A delete that found its value removes exactly one entry.
  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && cmd.del_en) |=> (count_q == count_t'($past(count_q) - count_t'(1))))
    else $error("delete did not remove one entry");

  // The input is held back only while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

endmodule
